@@ sv/ocu_pkg.sv @@
`default_nettype none
package ocu_pkg;

  typedef enum logic [1:0] {
    FUNC_MOTION = 2'd0,
    FUNC_BTN_DN = 2'd1,
    FUNC_BTN_UP = 2'd2,
    FUNC_WHEEL  = 2'd3
  } func_t;

  localparam logic [2:0] RIGHT_BUTTON = 3'd3;

  // angles are kept in 2^-ANGLE_FRACTION_BITS degree
  localparam int ANGLE_FRACTION_BITS = 8;
  localparam int ATAN_BITS = 20;
  localparam logic [13:0] DIST_MIN = 14'd256;
  localparam logic [13:0] DIST_MAX = 14'd12800;
  localparam logic [13:0] DIST_RESET = 14'd2560;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  localparam logic [1:0] REG_TURN_SPEED = 2'd0;
  localparam logic [1:0] REG_CENTER_X   = 2'd1;
  localparam logic [1:0] REG_CENTER_Y   = 2'd2;
  localparam logic [1:0] REG_CENTER_Z   = 2'd3;

  // CORDIC arctangent table, 2^-20 degree
  function automatic logic signed [27:0] atan_lut(input logic [4:0] i);
    logic signed [27:0] r;
    unique case (i)
      5'd0:  r = 28'sd47185920;
      5'd1:  r = 28'sd27855475;
      5'd2:  r = 28'sd14718068;
      5'd3:  r = 28'sd7471121;
      5'd4:  r = 28'sd3750058;
      5'd5:  r = 28'sd1876857;
      5'd6:  r = 28'sd938658;
      5'd7:  r = 28'sd469357;
      5'd8:  r = 28'sd234682;
      5'd9:  r = 28'sd117342;
      5'd10: r = 28'sd58671;
      5'd11: r = 28'sd29335;
      5'd12: r = 28'sd14668;
      5'd13: r = 28'sd7334;
      5'd14: r = 28'sd3667;
      5'd15: r = 28'sd1833;
      5'd16: r = 28'sd917;
      5'd17: r = 28'sd458;
      5'd18: r = 28'sd229;
      5'd19: r = 28'sd115;
      5'd20: r = 28'sd57;
      5'd21: r = 28'sd29;
      5'd22: r = 28'sd14;
      5'd23: r = 28'sd7;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_WRAP,
    ST_YAW,
    ST_PITCH,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } back_state_t;

  // work handed from the front part to the back part
  typedef struct packed {
    logic [1:0]          func;
    logic signed [11:0]  move_dx;
    logic signed [11:0]  move_dy;
    logic [2:0]          button_id;
    logic signed [7:0]   wheel_steps;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/ocu_front.sv @@
`default_nettype none
// Accepts events, drops button events for buttons other than the right one, which
// cannot produce a result or change state, and queues the rest for the back part.
module ocu_front #(
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire ocu_pkg::cmd_t in_cmd,
  output logic              q_valid,
  output ocu_pkg::cmd_t     q_cmd,
  input  wire logic         q_take
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ocu_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          keep;
  logic          wr, rd;

  // buttons other than the right one do nothing
  assign keep = !((in_cmd.func == ocu_pkg::FUNC_BTN_DN || in_cmd.func == ocu_pkg::FUNC_BTN_UP)
                  && in_cmd.button_id != ocu_pkg::RIGHT_BUTTON);
  assign in_full = (cnt_r == (AW+1)'(DEPTH));
  assign wr = in_push && !in_full && keep;
  assign rd = q_take && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

@@ sv/ocu_cordic.sv @@
`default_nettype none
// Iterative rotation CORDIC: one stage per cycle, Q1.14 sine and cosine out.
module ocu_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [17:0] angle,
  output logic                    done,
  output logic signed [15:0]      sin_q,
  output logic signed [15:0]      cos_q
);
  localparam int SH = ocu_pkg::ATAN_BITS - ocu_pkg::ANGLE_FRACTION_BITS;
  localparam int SW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES + 1) : 1;
  localparam logic signed [31:0] FULL = 32'sd360 <<< ocu_pkg::ATAN_BITS;
  localparam logic signed [31:0] HALF = 32'sd180 <<< ocu_pkg::ATAN_BITS;
  localparam logic signed [31:0] QUAR = 32'sd90 <<< ocu_pkg::ATAN_BITS;

  logic signed [33:0] x_r, y_r;
  logic signed [31:0] a_r;
  logic               neg_r, busy_r, done_r;
  logic [SW-1:0]      i_r;

  logic signed [31:0] a0, a1;
  logic               n1;
  logic signed [33:0] xs, ys, xf, yf;
  logic signed [33:0] xr, yr;

  // range reduction; inputs stay within one turn either way
  always_comb begin
    a0 = 32'(angle) <<< SH;
    if (a0 < 0) a0 = a0 + FULL;
    if (a0 >= HALF) a0 = a0 - FULL;
    n1 = 1'b0;
    a1 = a0;
    if (a0 > QUAR) begin
      a1 = a0 - HALF;
      n1 = 1'b1;
    end else if (a0 < -QUAR) begin
      a1 = a0 + HALF;
      n1 = 1'b1;
    end
  end

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign xf = neg_r ? -x_r : x_r;
  assign yf = neg_r ? -y_r : y_r;
  assign xr = (xf + 34'sd32768) >>> 16;
  assign yr = (yf + 34'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= 34'(ocu_pkg::CORDIC_GAIN);
      y_r <= '0;
      a_r <= a1;
      neg_r <= n1;
      i_r <= '0;
    end else if (busy_r) begin
      if (a_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        a_r <= a_r - 32'(ocu_pkg::atan_lut(5'(i_r)));
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        a_r <= a_r + 32'(ocu_pkg::atan_lut(5'(i_r)));
      end
      i_r <= i_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) busy_r <= 1'b1;
      else if (busy_r && i_r == SW'(CORDIC_STAGES - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign cos_q = (xr > 34'sd16384) ? ocu_pkg::Q14_ONE :
                 (xr < -34'sd16384) ? -ocu_pkg::Q14_ONE : 16'(xr);
  assign sin_q = (yr > 34'sd16384) ? ocu_pkg::Q14_ONE :
                 (yr < -34'sd16384) ? -ocu_pkg::Q14_ONE : 16'(yr);
endmodule
`default_nettype wire

@@ sv/ocu_back.sv @@
`default_nettype none
// Executes queued events: state update, then for a result a yaw wrap (motion only),
// two CORDIC passes, products and the result register.
module ocu_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire ocu_pkg::cmd_t      q_cmd,
  output logic                    q_take,
  input  wire logic [11:0]        turn_speed,
  input  wire logic signed [15:0] center_x,
  input  wire logic signed [15:0] center_y,
  input  wire logic signed [15:0] center_z,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [16:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [16:0]      out_pos_z,
  output logic signed [15:0]      out_up_x,
  output logic signed [15:0]      out_up_y,
  output logic signed [15:0]      out_up_z
);
  localparam int AF = ocu_pkg::ANGLE_FRACTION_BITS;
  localparam logic signed [31:0] PLIM = 32'sd89 <<< AF;
  // a full turn is 45 * 2^(AF+3): keep the low bits, reduce the upper part mod 45
  localparam int LOW_BITS = AF + 3;
  localparam logic [31:0] WRAP_BIAS = 32'd4140;   // 92 * 45, upper part made positive
  localparam logic [14:0] RECIP_45 = 15'd23302;   // ceil(2^20 / 45)

  ocu_pkg::back_state_t st_r, st_nxt;

  logic signed [17:0] yaw_r;
  logic signed [17:0] pitch_r;
  logic [13:0]        dist_r;
  logic               locked_r;

  logic signed [15:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [31:0] t1_r, t2_r, t3_r, t4_r, t5_r;
  logic               full_r;
  logic signed [31:0] sum_r;
  logic [7:0]         quot_r;

  logic               c_start, c_done;
  logic signed [17:0] c_angle;
  logic signed [15:0] c_sin, c_cos;

  logic signed [31:0] yaw_sum, pit_sum, pit_c, dist_n;
  logic [31:0]        wrap_u;
  logic [7:0]         quot_n;
  logic [5:0]         wrap_hi;
  logic signed [17:0] yaw_w;
  logic               run, emit;

  ocu_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .angle(c_angle),
    .done(c_done), .sin_q(c_sin), .cos_q(c_cos)
  );

  always_comb begin
    yaw_sum = 32'(yaw_r) + 32'(q_cmd.move_dx) * 32'(signed'({1'b0, turn_speed}));
    pit_sum = 32'(pitch_r) + 32'(q_cmd.move_dy) * 32'(signed'({1'b0, turn_speed}));
    pit_c = (pit_sum > PLIM) ? PLIM : (pit_sum < -PLIM) ? -PLIM : pit_sum;
    dist_n = 32'(signed'({1'b0, dist_r})) - (32'(q_cmd.wheel_steps) <<< 8);
    if (dist_n < signed'(32'(ocu_pkg::DIST_MIN))) dist_n = signed'(32'(ocu_pkg::DIST_MIN));
    else if (dist_n > signed'(32'(ocu_pkg::DIST_MAX))) dist_n = signed'(32'(ocu_pkg::DIST_MAX));
  end

  // yaw modulo a full turn: quotient by reciprocal in ST_QUOT, then remainder in ST_WRAP
  always_comb begin
    wrap_u = 32'(sum_r >>> LOW_BITS) + WRAP_BIAS;
    quot_n = 8'((29'(wrap_u[13:0]) * 29'(RECIP_45)) >> 20);
    wrap_hi = 6'(wrap_u[13:0] - 14'(quot_r) * 14'd45);
    yaw_w = signed'(18'({wrap_hi, sum_r[LOW_BITS-1:0]}));
  end

  assign run = (st_r == ocu_pkg::ST_IDLE) && q_valid && !full_r;
  assign emit = run && ((q_cmd.func == ocu_pkg::FUNC_WHEEL) ||
                        (q_cmd.func == ocu_pkg::FUNC_MOTION && !locked_r));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ocu_pkg::ST_IDLE: begin
        if (emit) begin
          st_nxt = (q_cmd.func == ocu_pkg::FUNC_WHEEL) ? ocu_pkg::ST_YAW : ocu_pkg::ST_QUOT;
        end
      end
      ocu_pkg::ST_QUOT:  st_nxt = ocu_pkg::ST_WRAP;
      ocu_pkg::ST_WRAP:  st_nxt = ocu_pkg::ST_YAW;
      ocu_pkg::ST_YAW:   if (c_done) st_nxt = ocu_pkg::ST_PITCH;
      ocu_pkg::ST_PITCH: if (c_done) st_nxt = ocu_pkg::ST_MUL1;
      ocu_pkg::ST_MUL1:  st_nxt = ocu_pkg::ST_MUL2;
      ocu_pkg::ST_MUL2:  st_nxt = ocu_pkg::ST_DONE;
      ocu_pkg::ST_DONE:  st_nxt = ocu_pkg::ST_IDLE;
      default:           st_nxt = ocu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = run;
    c_start = 1'b0;
    c_angle = yaw_r;
    unique case (st_r)
      ocu_pkg::ST_IDLE: begin
        c_start = emit && (q_cmd.func == ocu_pkg::FUNC_WHEEL);
      end
      ocu_pkg::ST_WRAP: begin
        c_start = 1'b1;
        c_angle = yaw_w;
      end
      ocu_pkg::ST_YAW: begin
        c_start = c_done;
        c_angle = pitch_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ocu_pkg::ST_IDLE;
      yaw_r <= '0;
      pitch_r <= '0;
      dist_r <= ocu_pkg::DIST_RESET;
      locked_r <= 1'b1;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (run) begin
        unique case (ocu_pkg::func_t'(q_cmd.func))
          ocu_pkg::FUNC_MOTION: if (!locked_r) pitch_r <= 18'(pit_c);
          ocu_pkg::FUNC_BTN_DN: if (q_cmd.button_id == ocu_pkg::RIGHT_BUTTON) locked_r <= 1'b0;
          ocu_pkg::FUNC_BTN_UP: if (q_cmd.button_id == ocu_pkg::RIGHT_BUTTON) locked_r <= 1'b1;
          ocu_pkg::FUNC_WHEEL:  dist_r <= 14'(dist_n);
          default: ;
        endcase
      end
      if (st_r == ocu_pkg::ST_WRAP) yaw_r <= yaw_w;
      if (st_r == ocu_pkg::ST_DONE) full_r <= 1'b1;
      else if (out_pop && full_r) full_r <= 1'b0;
    end
  end

  // datapath: yaw wrap, trig results, then two product stages, then output register
  always_ff @(posedge clk) begin
    if (run && q_cmd.func == ocu_pkg::FUNC_MOTION) sum_r <= yaw_sum;
    if (st_r == ocu_pkg::ST_QUOT) quot_r <= quot_n;
    if (st_r == ocu_pkg::ST_YAW && c_done) begin
      sy_r <= c_sin;
      cy_r <= c_cos;
    end
    if (st_r == ocu_pkg::ST_PITCH && c_done) begin
      sp_r <= c_sin;
      cp_r <= c_cos;
    end
    if (st_r == ocu_pkg::ST_MUL1) begin
      t1_r <= 32'(signed'({1'b0, dist_r})) * 32'(cp_r);
      t2_r <= 32'(signed'({1'b0, dist_r})) * 32'(sp_r);
      t4_r <= -(32'(sp_r) * 32'(cy_r));
      t5_r <= -(32'(sp_r) * 32'(sy_r));
    end
    if (st_r == ocu_pkg::ST_MUL2) begin
      t1_r <= 32'((48'(t1_r) * 48'(cy_r) + 48'sd134217728) >>> 28);
      t3_r <= 32'((48'(t1_r) * 48'(sy_r) + 48'sd134217728) >>> 28);
      t2_r <= (t2_r + 32'sd8192) >>> 14;
      t4_r <= (t4_r + 32'sd8192) >>> 14;
      t5_r <= (t5_r + 32'sd8192) >>> 14;
    end
    if (st_r == ocu_pkg::ST_DONE) begin
      out_pos_x <= 17'(32'(center_x) + t1_r);
      out_pos_y <= 17'(32'(center_y) + t2_r);
      out_pos_z <= 17'(32'(center_z) + t3_r);
      out_up_x <= 16'(t4_r);
      out_up_y <= cp_r;
      out_up_z <= 16'(t5_r);
    end
  end

  assign out_empty = !full_r;
endmodule
`default_nettype wire

@@ sv/orbit_camera_update.sv @@
`default_nettype none
// Channel  | Ports                               | Transaction
// input    | in_push, in_full, in_* fields       | push && !full
// result   | out_pop, out_empty, out_* fields    | pop && !empty
// config   | cfg_psel/penable/pwrite/paddr/...   | psel && penable && pwrite
//
// A wheel event's result goes through two passes of one shared iterative CORDIC, the
// product stages and the output register; an unlocked motion event first passes the
// yaw wrap (ST_QUOT, ST_WRAP). Button events only update state when the back takes them.
// Reset is synchronous, active low; state returns to yaw 0, pitch 0, distance 10, locked.
// A two-entry queue sits between the event front and the back; a held result
// stalls the back while the front keeps accepting until its queue fills.
module orbit_camera_update #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [11:0] in_move_dx,
  input  wire logic signed [11:0] in_move_dy,
  input  wire logic [2:0]         in_button_id,
  input  wire logic signed [7:0]  in_wheel_steps,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [16:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [16:0]      out_pos_z,
  output logic signed [15:0]      out_up_x,
  output logic signed [15:0]      out_up_y,
  output logic signed [15:0]      out_up_z,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  logic [11:0]        ts_r;
  logic signed [15:0] cx_r, cy_r, cz_r;
  ocu_pkg::cmd_t      in_cmd, q_cmd;
  logic               q_valid, q_take;
  logic [1:0]         ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= 12'd26;
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        ocu_pkg::REG_TURN_SPEED: ts_r <= cfg_pwdata[11:0];
        ocu_pkg::REG_CENTER_X:   cx_r <= cfg_pwdata[15:0];
        ocu_pkg::REG_CENTER_Y:   cy_r <= cfg_pwdata[15:0];
        ocu_pkg::REG_CENTER_Z:   cz_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      ocu_pkg::REG_TURN_SPEED: cfg_prdata = {20'd0, ts_r};
      ocu_pkg::REG_CENTER_X:   cfg_prdata = {16'd0, cx_r};
      ocu_pkg::REG_CENTER_Y:   cfg_prdata = {16'd0, cy_r};
      ocu_pkg::REG_CENTER_Z:   cfg_prdata = {16'd0, cz_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign in_cmd = '{func: in_func, move_dx: in_move_dx, move_dy: in_move_dy,
                    button_id: in_button_id, wheel_steps: in_wheel_steps};

  ocu_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  ocu_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
    .turn_speed(ts_r), .center_x(cx_r), .center_y(cy_r), .center_z(cz_r),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_up_x(out_up_x), .out_up_y(out_up_y), .out_up_z(out_up_z)
  );
endmodule
`default_nettype wire
